// File: rtl/core/status_request_responder_unit_assert.svh
// Assertion macros shared by the status request responder checkers.
// Depends on nothing; take it in with a plain include of the bare file name.
`ifndef STATUS_REQUEST_RESPONDER_UNIT_ASSERT_SVH
`define STATUS_REQUEST_RESPONDER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sru_pkg.sv
// Shared types, codes and packet layout for the status request responder.
// No dependencies; every module of the block imports this package.
package sru_pkg;

    // One request byte as it crosses the input channel.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_transfer;
    } req_t;

    // One result as it crosses the output channel.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] resp_word;
        logic        is_last;
    } resp_t;

    // Configuration registers, bundled for the back end.
    typedef struct packed {
        logic        [23:0] accum_time_tenths;
        logic        [31:0] uptime_ms;
        logic        [31:0] serial_no;
        logic signed [7:0]  board_temp;
        logic        [7:0]  fw_version;
        logic        [7:0]  status_bits;
        logic        [3:0]  build_no;
        logic        [7:0]  device_kind;
    } cfg_t;

    // Result status codes.
    localparam logic [1:0] ST_WORD    = 2'd0;
    localparam logic [1:0] ST_BAD_SUM = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_BAD_LEN = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCUM_TIME  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REALTIME    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_NO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_TEMP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FW_VERSION  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_BITS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BUILD_NO    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_KIND = 3'd7;
    localparam int unsigned CFG_DATA_W = 32;

    // Request framing.
    localparam logic [3:0] HDR_BYTES = 4'd6;
    localparam logic [3:0] REQ_LEN   = 4'd8;
    localparam logic [3:0] COUNT_SAT = 4'd9;

    // Response packet: 36 words, the last one carries the checksum.
    localparam int unsigned     WORD_IDX_W = 6;
    localparam logic [5:0]      LAST_WORD  = 6'd35;
    localparam logic [15:0]     RESP_SYNC  = 16'hF5FA;
    localparam logic [15:0]     RESP_PID   = 16'h8001;
    localparam logic [15:0]     RESP_LEN   = 16'h0040;

    // Expected request header byte at a given position.
    function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
        logic [7:0] b;
        unique case (pos)
            3'd0:    b = 8'hF5;
            3'd1:    b = 8'hFA;
            3'd2:    b = 8'h01;
            3'd3:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Packet word k (bytes 2k and 2k+1, first byte high); excludes the checksum word.
    function automatic logic [15:0] packet_word(input logic [5:0] k, input cfg_t c);
        logic [15:0] w;
        unique case (k)
            6'd0:    w = RESP_SYNC;
            6'd1:    w = RESP_PID;
            6'd2:    w = RESP_LEN;
            6'd9:    w = {8'h00, c.accum_time_tenths[7:0]};
            6'd10:   w = {c.accum_time_tenths[15:8], c.accum_time_tenths[23:16]};
            6'd13:   w = {c.uptime_ms[7:0], c.uptime_ms[15:8]};
            6'd14:   w = {c.uptime_ms[23:16], c.uptime_ms[31:24]};
            6'd15:   w = {c.fw_version, 8'h00};
            6'd16:   w = {c.serial_no[7:0], c.serial_no[15:8]};
            6'd17:   w = {c.serial_no[23:16], c.serial_no[31:24]};
            6'd20:   w = {c.board_temp, c.status_bits};
            6'd21:   w = {12'h000, c.build_no};
            6'd22:   w = {c.device_kind, 8'h00};
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/sru_front.sv
// Front end: tracks one request transfer and classifies it at its last byte.
// Depends on sru_pkg.
module sru_front
    import sru_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  req_t       req,
    output logic       push,
    output logic [1:0] verdict
);

    logic [3:0]  count_reg, count_next;
    logic        match_reg, match_next;
    logic [15:0] hsum_reg, hsum_next;
    logic [7:0]  chk_hi_reg, chk_hi_next;
    logic [3:0]  count_inc;
    logic        in_hdr;
    logic [15:0] chk_total;

    always_comb
    begin
        in_hdr    = (count_reg < HDR_BYTES);
        count_inc = (count_reg < COUNT_SAT) ? count_reg + 4'd1 : count_reg;

        match_next  = match_reg;
        hsum_next   = hsum_reg;
        chk_hi_next = chk_hi_reg;
        if (in_hdr)
        begin
            if (req.rx_byte != hdr_byte(count_reg[2:0]))
                match_next = 1'b0;
            hsum_next = hsum_reg + {8'h00, req.rx_byte};
        end
        else if (count_reg == HDR_BYTES)
        begin
            chk_hi_next = req.rx_byte;
        end

        // A verdict only matters at length eight, where this byte is the low check byte.
        chk_total = hsum_reg + {chk_hi_reg, req.rx_byte};
        priority if (count_inc != REQ_LEN)
            verdict = ST_BAD_LEN;
        else if (!match_next)
            verdict = ST_UNKNOWN;
        else if (chk_total != 16'h0000)
            verdict = ST_BAD_SUM;
        else
            verdict = ST_WORD;

        push = accept && req.end_of_transfer;

        count_next = count_inc;
        if (push)
        begin
            // Drop the request state once the transfer ends.
            count_next  = 4'd0;
            match_next  = 1'b1;
            hsum_next   = 16'h0000;
            chk_hi_next = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 4'd0;
            match_reg  <= 1'b1;
            hsum_reg   <= 16'h0000;
            chk_hi_reg <= 8'h00;
        end
        else if (accept)
        begin
            count_reg  <= count_next;
            match_reg  <= match_next;
            hsum_reg   <= hsum_next;
            chk_hi_reg <= chk_hi_next;
        end
    end

endmodule

// File: rtl/core/sru_queue.sv
// Small verdict queue between the front and back ends.
// Depends on sru_pkg.
module sru_queue
    import sru_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [1:0] din,
    output logic       full,
    input  logic       pop,
    output logic       valid,
    output logic [1:0] dout
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [1:0]       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_FULL);
    assign valid = (count_reg != '0);
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// File: rtl/core/sru_back.sv
// Back end: turns verdicts into results, streaming the status packet word by word.
// Depends on sru_pkg.
module sru_back
    import sru_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  logic [1:0] q_data,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output resp_t      out_data
);

    logic                  active_reg, active_next;
    logic [WORD_IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]           sum_reg, sum_next;
    logic                  out_valid_reg, out_valid_next;
    resp_t                 out_data_reg;

    logic                  load, emit, word_ok, last_word;
    logic [1:0]            cur_status;
    logic [WORD_IDX_W-1:0] cur_idx;
    logic [15:0]           word_val, sum_base;
    resp_t                 resp;

    always_comb
    begin
        // Output slot frees when empty or being drained this cycle.
        load       = !out_valid_reg || out_ready;
        cur_status = active_reg ? ST_WORD : q_data;
        cur_idx    = active_reg ? idx_reg : '0;
        emit       = load && (active_reg || q_valid);
        pop        = load && !active_reg && q_valid;
        word_ok    = (cur_status == ST_WORD);
        last_word  = (cur_idx == LAST_WORD);

        word_val = last_word ? (16'h0000 - sum_reg) : packet_word(cur_idx, cfg);

        resp.status    = cur_status;
        resp.resp_word = word_ok ? word_val : 16'h0000;
        resp.is_last   = !word_ok || last_word;

        sum_base       = (cur_idx == '0) ? 16'h0000 : sum_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = load ? emit : out_valid_reg;
        if (emit)
        begin
            active_next = word_ok && !last_word;
            idx_next    = cur_idx + WORD_IDX_W'(1);
            sum_next    = sum_base + {8'h00, word_val[15:8]} + {8'h00, word_val[7:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            sum_reg       <= 16'h0000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= resp;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/core/status_request_responder_unit.sv
// Status request responder: answers an eight-byte status request with a packet or an error result.
// Depends on sru_pkg, sru_front, sru_queue and sru_back.
//
// Request bytes enter on the in channel at one transfer per cycle; in_ready drops
// only while the verdict queue (QUEUE_DEPTH entries) is full. Every transfer
// that ends with end_of_transfer produces either a single error result (status
// bad length, unknown header or bad checksum, resp_word zero, is_last set) or,
// for a valid request, 36 status-packet words streamed at one word per cycle
// while out_ready holds, is_last on the final word. The front end tracks the
// byte count, header match and checksum and judges the request at its last
// byte; the verdict is written into the queue, and the back end registers its
// first result once it takes the verdict from the queue. The back end emits one
// result per cycle while out_ready holds, so a valid request occupies it until
// all 36 words are out; up to QUEUE_DEPTH further verdicts wait behind it while
// the front keeps taking bytes. The packet checksum accumulates as words go out, so
// no separate pass is spent on it. Configuration registers are plain writes through
// cfg_we / cfg_index / cfg_data and must only change while the block is idle.
module status_request_responder_unit
    import sru_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  req_t                  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output resp_t                 out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Register values after reset.
    localparam cfg_t CFG_RESET = '{
        accum_time_tenths: 24'd420,
        uptime_ms:         32'd42000,
        serial_no:         32'd9100,
        board_temp:        8'sd30,
        fw_version:        8'd96,
        status_bits:       8'd32,
        build_no:          4'd5,
        device_kind:       8'd0
    };

    cfg_t       cfg_reg;
    logic       accept;
    logic       push;
    logic [1:0] verdict;
    logic       q_full;
    logic       q_valid;
    logic [1:0] q_data;
    logic       pop;

    // Configuration register file: write only, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACCUM_TIME:  cfg_reg.accum_time_tenths <= cfg_data[23:0];
                CFG_REALTIME:    cfg_reg.uptime_ms         <= cfg_data;
                CFG_SERIAL_NO:   cfg_reg.serial_no         <= cfg_data;
                CFG_BOARD_TEMP:  cfg_reg.board_temp        <= cfg_data[7:0];
                CFG_FW_VERSION:  cfg_reg.fw_version        <= cfg_data[7:0];
                CFG_STATUS_BITS: cfg_reg.status_bits       <= cfg_data[7:0];
                CFG_BUILD_NO:    cfg_reg.build_no          <= cfg_data[3:0];
                CFG_DEVICE_KIND: cfg_reg.device_kind       <= cfg_data[7:0];
            endcase
        end
    end

    // Hold the input while no room is left for another verdict.
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    sru_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .req     (in_data),
        .push    (push),
        .verdict (verdict)
    );

    sru_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (verdict),
        .full  (q_full),
        .pop   (pop),
        .valid (q_valid),
        .dout  (q_data)
    );

    sru_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: rtl/core/sru_checker.sv
// Port-level checks for the status request responder, attached by bind.
// Depends on sru_pkg and status_request_responder_unit_assert.svh.
`include "status_request_responder_unit_assert.svh"

module sru_checker
    import sru_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  out_valid,
    input logic  out_ready,
    input resp_t out_data
);

    // A stalled result holds its payload.
    `SRU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

    // An error result stands alone with an empty word.
    `SRU_ASSERT_NOW(a_err_single, clk, rst_n, out_valid && out_data.status != ST_WORD, out_data.is_last && out_data.resp_word == 16'h0000, "error result not single")

    // A packet streams without gaps once its first word is taken.
    `SRU_ASSERT_NEXT(a_pkt_stream, clk, rst_n, out_valid && out_ready && out_data.status == ST_WORD && !out_data.is_last, out_valid && out_data.status == ST_WORD, "packet stream broke")

endmodule

bind status_request_responder_unit sru_checker u_sru_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: tb/tb_status_request_responder_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for status_request_responder_unit: request framing,
// verdicts and the 36-word status packet. Depends on sru_pkg and the RTL top.
module tb_status_request_responder_unit;
    import sru_pkg::*;

    // Request framing and packet layout, as the block is meant to behave.
    localparam int REQUEST_LEN     = 8;
    localparam int HEADER_LEN      = 6;
    localparam int COUNT_CEILING   = 9;
    localparam int PACKET_BYTES    = 72;
    localparam int PACKET_WORDS    = 36;
    localparam int SUMMED_BYTES    = 70;

    // Run shaping.
    localparam int DIRECTED_ROWS   = 25;
    localparam int PHASE_COUNT     = 5;
    localparam int PHASE_ITEMS     = 80;
    localparam int SETTLE_CYCLES   = 8;     // settle time after the last expected result has drained
    localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall that backs up the input
    localparam int STALL_LIMIT     = 3000;  // cycles with no transfer before giving up
    localparam int REPORT_LIMIT    = 10;

    // Register setting styles, one per phase.
    localparam int SET_FLOOR   = 0;
    localparam int SET_CEILING = 1;
    localparam int SET_RANDOM  = 2;

    // A verdict that a directed row states outright, carried alongside each byte.
    typedef struct packed {
        logic       has_verdict;
        logic [1:0] verdict;
    } verdict_note_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_transfer;
        logic       has_verdict;
        logic [1:0] verdict;
    } table_row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    req_t                  in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    resp_t                 out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Idle and back-pressure controls, changed per phase.
    logic tx_idle     = 1'b1;
    logic rx_idle     = 1'b1;
    logic pressure_go = 1'b0;
    logic hold_off    = 1'b0;

    // Shadow of the block: configuration and the request being framed.
    cfg_t        shadow_cfg;
    logic [3:0]  req_count;
    logic        hdr_ok;
    logic [15:0] hdr_sum;
    logic [15:0] rx_check;
    logic [7:0]  req_header [0:HEADER_LEN-1] = '{8'hF5, 8'hFA, 8'h01, 8'h01, 8'h00, 8'h00};

    resp_t         expected_results [$];
    verdict_note_t verdict_notes [$];
    int            mismatch_count = 0;
    int            bytes_offered  = 0;
    int            quiet_cycles   = 0;

    // Directed requests: a valid one at reset settings, then a bad checksum, an
    // unknown header and a one-byte transfer. Verdicts are typed in for the
    // error cases; the packet words are left to the predictor.
    table_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        {8'hF5, 1'b0, 1'b0, ST_WORD},
        {8'hFA, 1'b0, 1'b0, ST_WORD},
        {8'h01, 1'b0, 1'b0, ST_WORD},
        {8'h01, 1'b0, 1'b0, ST_WORD},
        {8'h00, 1'b0, 1'b0, ST_WORD},
        {8'h00, 1'b0, 1'b0, ST_WORD},
        {8'hFE, 1'b0, 1'b0, ST_WORD},
        {8'h0F, 1'b1, 1'b0, ST_WORD},
        {8'hF5, 1'b0, 1'b0, ST_WORD},
        {8'hFA, 1'b0, 1'b0, ST_WORD},
        {8'h01, 1'b0, 1'b0, ST_WORD},
        {8'h01, 1'b0, 1'b0, ST_WORD},
        {8'h00, 1'b0, 1'b0, ST_WORD},
        {8'h00, 1'b0, 1'b0, ST_WORD},
        {8'hFF, 1'b0, 1'b0, ST_WORD},
        {8'hFF, 1'b1, 1'b1, ST_BAD_SUM},
        {8'hF5, 1'b0, 1'b0, ST_WORD},
        {8'hFA, 1'b0, 1'b0, ST_WORD},
        {8'h01, 1'b0, 1'b0, ST_WORD},
        {8'h01, 1'b0, 1'b0, ST_WORD},
        {8'h00, 1'b0, 1'b0, ST_WORD},
        {8'hFF, 1'b0, 1'b0, ST_WORD},
        {8'h00, 1'b0, 1'b0, ST_WORD},
        {8'h00, 1'b1, 1'b1, ST_UNKNOWN},
        {8'hFF, 1'b1, 1'b1, ST_BAD_LEN}
    };

    status_request_responder_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Fold one accepted request byte into the shadow framing state. At the end
    // of a transfer, queue the verdict, or all 36 packet words for a valid one.
    task automatic absorb_request_byte(input req_t item, input verdict_note_t note);
        logic [1:0]  verdict;
        logic [7:0]  pkt [0:PACKET_BYTES-1];
        logic [15:0] pkt_sum;
        logic [15:0] pkt_check;
        resp_t       word;
        if (req_count < HEADER_LEN)
        begin
            if (item.rx_byte != req_header[req_count])
                hdr_ok = 1'b0;
            hdr_sum = hdr_sum + {8'h00, item.rx_byte};
        end
        else if (req_count == HEADER_LEN)
            rx_check[15:8] = item.rx_byte;
        else if (req_count == HEADER_LEN + 1)
            rx_check[7:0] = item.rx_byte;
        if (req_count < COUNT_CEILING)
            req_count = req_count + 4'd1;
        if (!item.end_of_transfer)
            return;

        // Length beats header, header beats checksum.
        if (req_count != REQUEST_LEN)
            verdict = ST_BAD_LEN;
        else if (!hdr_ok)
            verdict = ST_UNKNOWN;
        else if (hdr_sum + rx_check != 16'h0000)
            verdict = ST_BAD_SUM;
        else
            verdict = ST_WORD;
        req_count = '0;
        hdr_ok    = 1'b1;
        hdr_sum   = '0;
        rx_check  = '0;

        if (note.has_verdict)
        begin
            expected_results.push_back({note.verdict, 16'h0000, 1'b1});
            return;
        end
        if (verdict != ST_WORD)
        begin
            expected_results.push_back({verdict, 16'h0000, 1'b1});
            return;
        end

        // Lay out the status packet byte by byte; multi-byte fields go little-endian.
        for (int k = 0; k < PACKET_BYTES; k++)
            pkt[k] = 8'h00;
        pkt[0]  = 8'hF5;
        pkt[1]  = 8'hFA;
        pkt[2]  = 8'h80;
        pkt[3]  = 8'h01;
        pkt[5]  = 8'h40;
        pkt[19] = shadow_cfg.accum_time_tenths[7:0];
        pkt[20] = shadow_cfg.accum_time_tenths[15:8];
        pkt[21] = shadow_cfg.accum_time_tenths[23:16];
        pkt[26] = shadow_cfg.uptime_ms[7:0];
        pkt[27] = shadow_cfg.uptime_ms[15:8];
        pkt[28] = shadow_cfg.uptime_ms[23:16];
        pkt[29] = shadow_cfg.uptime_ms[31:24];
        pkt[30] = shadow_cfg.fw_version;
        pkt[32] = shadow_cfg.serial_no[7:0];
        pkt[33] = shadow_cfg.serial_no[15:8];
        pkt[34] = shadow_cfg.serial_no[23:16];
        pkt[35] = shadow_cfg.serial_no[31:24];
        pkt[40] = shadow_cfg.board_temp;
        pkt[41] = shadow_cfg.status_bits;
        pkt[43] = {4'h0, shadow_cfg.build_no};
        pkt[44] = shadow_cfg.device_kind;
        pkt_sum = '0;
        for (int k = 0; k < SUMMED_BYTES; k++)
            pkt_sum = pkt_sum + {8'h00, pkt[k]};
        pkt_check = 16'h0000 - pkt_sum;
        pkt[70] = pkt_check[15:8];
        pkt[71] = pkt_check[7:0];
        for (int k = 0; k < PACKET_WORDS; k++)
        begin
            word.status    = ST_WORD;
            word.resp_word = {pkt[2 * k], pkt[2 * k + 1]};
            word.is_last   = (k == PACKET_WORDS - 1);
            expected_results.push_back(word);
        end
    endtask

    task automatic flag_mismatch(input string what, input resp_t want, input resp_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected status %0d word %h last %b, got status %0d word %h last %b",
                     $realtime, what, want.status, want.resp_word, want.is_last,
                     got.status, got.resp_word, got.is_last);
    endtask

    // Check results first: nothing accepted on the input at this edge can have
    // caused a result already, so a result must match an older expectation.
    always @(posedge clk)
    begin : check_port
        resp_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    flag_mismatch("unexpected result", '0, out_data);
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.status !== want.status || out_data.resp_word !== want.resp_word
                            || out_data.is_last !== want.is_last)
                        flag_mismatch("result mismatch", want, out_data);
                end
            end
            if (in_valid && in_ready)
                absorb_request_byte(in_data, verdict_notes.pop_front());
        end
    end

    // Watchdog: end the run if neither channel moves a transfer for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: draw a stall before each result, and hold off completely while
    // the pressure window is open.
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 3) : 0;
            if (stall > 0 || hold_off)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_off)
                    @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Pressure window: count the stall here so the sender keeps offering bytes
    // and the verdict queue fills up behind a blocked output.
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offer one byte after a random gap and hold it until the transfer completes.
    // Valid stays high between back-to-back bytes, so it is never dropped and
    // raised in one step.
    task automatic send_byte(input logic [7:0] b, input logic eot, input verdict_note_t note);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= {b, eot};
        in_valid <= 1'b1;
        verdict_notes.push_back(note);
        bytes_offered++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // One random request: mostly well-framed ones with random defects, the rest
    // wrong lengths (short and saturating long) and plain noise.
    task automatic send_random_request();
        logic [7:0]  frame [$];
        logic [15:0] frame_sum;
        logic [15:0] frame_check;
        int          kind;
        int          len;
        int          pos;
        kind = $urandom_range(0, 99);
        for (int k = 0; k < HEADER_LEN; k++)
            frame.push_back(req_header[k]);
        if (kind >= 55 && kind < 70)
        begin
            pos = $urandom_range(0, HEADER_LEN - 1);
            frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
            if ($urandom_range(0, 1))
                frame[$urandom_range(0, HEADER_LEN - 1)] = 8'($urandom);
        end
        frame_sum = '0;
        for (int k = 0; k < HEADER_LEN; k++)
            frame_sum = frame_sum + {8'h00, frame[k]};
        frame_check = 16'h0000 - frame_sum;
        if (kind >= 40 && kind < 55)
            frame_check = frame_check ^ 16'($urandom_range(1, 65535));
        else if (kind >= 55 && kind < 70 && $urandom_range(0, 1))
            frame_check = 16'($urandom);
        frame.push_back(frame_check[15:8]);
        frame.push_back(frame_check[7:0]);
        if (kind >= 70 && kind < 88)
        begin
            len = $urandom_range(0, 1) ? $urandom_range(1, REQUEST_LEN - 1)
                                       : $urandom_range(REQUEST_LEN + 1, 14);
            while (frame.size() > len)
                void'(frame.pop_back());
            while (frame.size() < len)
                frame.push_back(8'($urandom));
        end
        else if (kind >= 88)
            for (int k = 0; k < frame.size(); k++)
                frame[k] = 8'($urandom);
        for (int k = 0; k < frame.size(); k++)
            send_byte(frame[k], k == frame.size() - 1, '0);
    endtask

    // Register value for a given setting style; board_temp takes its signed edges.
    function automatic logic [31:0] setting_value(input int mode, input logic [CFG_IDX_W-1:0] idx);
        if (mode == SET_RANDOM)
            return $urandom;
        if (idx == CFG_BOARD_TEMP)
            return (mode == SET_CEILING) ? 32'h0000_007F : 32'h0000_0080;
        return (mode == SET_CEILING) ? 32'hFFFF_FFFF : 32'h0000_0000;
    endfunction

    // Write every register once, one per cycle, and mirror it into the shadow.
    task automatic program_settings(input int mode);
        logic [31:0]          value;
        logic [CFG_IDX_W-1:0] idx;
        for (int i = 0; i <= int'(CFG_DEVICE_KIND); i++)
        begin
            idx   = i[CFG_IDX_W-1:0];
            value = setting_value(mode, idx);
            case (idx)
                CFG_ACCUM_TIME:  shadow_cfg.accum_time_tenths = value[23:0];
                CFG_REALTIME:    shadow_cfg.uptime_ms         = value;
                CFG_SERIAL_NO:   shadow_cfg.serial_no         = value;
                CFG_BOARD_TEMP:  shadow_cfg.board_temp        = value[7:0];
                CFG_FW_VERSION:  shadow_cfg.fw_version        = value[7:0];
                CFG_STATUS_BITS: shadow_cfg.status_bits       = value[7:0];
                CFG_BUILD_NO:    shadow_cfg.build_no          = value[3:0];
                CFG_DEVICE_KIND: shadow_cfg.device_kind       = value[7:0];
                default: ;
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Drop valid, step past the edge that queued the last expectations, wait for
    // every result, then let the block settle before anything else changes.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int phase_mode [0:PHASE_COUNT-1];
        int phase_start;
        phase_mode = '{SET_CEILING, SET_FLOOR, SET_RANDOM, SET_RANDOM, SET_RANDOM};

        shadow_cfg.accum_time_tenths = 24'd420;
        shadow_cfg.uptime_ms         = 32'd42000;
        shadow_cfg.serial_no         = 32'd9100;
        shadow_cfg.board_temp        = 8'sd30;
        shadow_cfg.fw_version        = 8'd96;
        shadow_cfg.status_bits       = 8'd32;
        shadow_cfg.build_no          = 4'd5;
        shadow_cfg.device_kind       = 8'd0;
        req_count = '0;
        hdr_ok    = 1'b1;
        hdr_sum   = '0;
        rx_check  = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs on the reset settings.
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_byte(directed_rows[r].rx_byte, directed_rows[r].end_of_transfer,
                      {directed_rows[r].has_verdict, directed_rows[r].verdict});
        drain_results();

        // Random phases, each on fresh settings with its own idle pattern.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            program_settings(phase_mode[p]);
            tx_idle = (p != 0 && p != 2);
            rx_idle = (p != 2 && p != 3);
            if (p == 0)
                pressure_go = 1'b1;
            phase_start = bytes_offered;
            while (bytes_offered - phase_start < PHASE_ITEMS)
                send_random_request();
            drain_results();
        end

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/sru_pkg.sv
rtl/core/sru_front.sv
rtl/core/sru_queue.sv
rtl/core/sru_back.sv
rtl/core/status_request_responder_unit.sv
rtl/core/sru_checker.sv
tb/tb_status_request_responder_unit.sv
